FILE: rtl/button_adjusted_led_blinker_top_assert.svh
// Assertion macros for the button-adjusted LED blinker.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef BUTTON_ADJUSTED_LED_BLINKER_TOP_ASSERT_SVH
`define BUTTON_ADJUSTED_LED_BLINKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define BAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bal_pkg.sv
// Shared types and constants for the button-adjusted LED blinker.
// No dependencies.
package bal_pkg;

  localparam int MS_PER_PERIOD_DEF = 1000;
  localparam int TIMER_WIDTH_DEF   = 16;

  localparam int FREQ_W    = 9;
  localparam int STEP_W    = 8;
  localparam int LIMIT_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1000);
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(5);
  localparam logic [FREQ_W-1:0]  FMAX_RST  = FREQ_W'(500);
  localparam logic [FREQ_W-1:0]  FREQ_RST  = FREQ_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_LIMIT = 2'd0,
    REG_FREQ_STEP   = 2'd1,
    REG_FREQ_MAX    = 2'd2
  } bal_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } bal_state_e;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic div_step;
    logic emit;
  } bal_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic short_hit;
    logic div_last;
    logic out_free;
  } bal_sts_t;

endpackage

FILE: rtl/bal_div.sv
// Radix-2 restoring divider: MS_PER_PERIOD / divisor, one quotient bit a cycle while step_i is high.
// Depends on bal_pkg.
module bal_div #(
  parameter int MS_PER_PERIOD = bal_pkg::MS_PER_PERIOD_DEF,
  localparam int DW = $clog2(MS_PER_PERIOD + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      step_i,
  input  logic [bal_pkg::FREQ_W-1:0] divisor_i,
  output logic [DW-1:0]             quotient_o,
  output logic                      last_o
);
  import bal_pkg::*;

  localparam int CW = $clog2(DW);

  logic [FREQ_W-1:0] rem_q, rem_d;
  logic [DW-1:0]     quo_q, quo_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [FREQ_W:0]   rem_sh;
  logic              fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    fits   = rem_sh >= {1'b0, divisor_i};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = DW'(MS_PER_PERIOD);
      cnt_d = '0;
    end else if (step_i) begin
      rem_d = fits ? FREQ_W'(rem_sh - {1'b0, divisor_i}) : rem_sh[FREQ_W-1:0];
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  assign last_o     = cnt_q == CW'(DW - 1);

endmodule

FILE: rtl/bal_dp.sv
// Datapath: config registers, button trackers, frequency, half period,
// blink counter and output register. Depends on bal_pkg and bal_div.
module bal_dp #(
  parameter int MS_PER_PERIOD = bal_pkg::MS_PER_PERIOD_DEF,
  parameter int TIMER_WIDTH   = bal_pkg::TIMER_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bal_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bal_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                         inc_level_i,
  input  logic                         dec_level_i,
  input  bal_pkg::bal_cmd_t            cmd_i,
  output bal_pkg::bal_sts_t            sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic                         led_out_o,
  output logic [bal_pkg::FREQ_W-1:0]   blink_rate_o,
  output logic                         rate_changed_o
);
  import bal_pkg::*;

  localparam int DW    = $clog2(MS_PER_PERIOD + 1);
  localparam int HW    = $clog2(MS_PER_PERIOD / 2 + 1);
  localparam int HRST  = (MS_PER_PERIOD / 4 < 1) ? 1 : MS_PER_PERIOD / 4;
  localparam int TW    = TIMER_WIDTH;
  localparam int CMPW  = (TW > LIMIT_W) ? TW : LIMIT_W;
  localparam logic [TW-1:0] HELD_MAX = {TW{1'b1}};

  logic [LIMIT_W-1:0] limit_q;
  logic [STEP_W-1:0]  step_q;
  logic [FREQ_W-1:0]  fmax_q;
  logic [FREQ_W-1:0]  freq_q, freq_d;
  logic               inc_prev_q, dec_prev_q;
  logic [TW-1:0]      inc_held_q, inc_held_d, dec_held_q, dec_held_d;
  logic               inc_short, dec_short;
  logic               changed_q;
  logic               led_q, led_d;
  logic [HW-1:0]      cnt_q, cnt_d;
  logic [HW-1:0]      half_q, half_new;
  logic [HW:0]        cnt_inc;
  logic               out_valid_q;
  logic               out_led_q;
  logic [FREQ_W-1:0]  out_rate_q;
  logic               out_chg_q;
  logic [DW-1:0]      quo;
  logic               div_last;
  logic [HW-1:0]      quo_half;
  logic [FREQ_W-1:0]  fmax;
  logic [FREQ_W:0]    sum;
  logic [FREQ_W-1:0]  f_inc;

  // One button: count hold, clear on press, judge on release.
  function automatic logic [TW:0] track(input logic level, input logic prev,
                                        input logic [TW-1:0] held,
                                        input logic [LIMIT_W-1:0] limit);
    logic [TW-1:0] h;
    logic          s;
    h = (!prev && held != HELD_MAX) ? held + TW'(1) : held;
    s = 1'b0;
    if (level != prev) begin
      if (!level) h = '0;
      else        s = CMPW'(h) < CMPW'(limit);
    end
    return {s, h};
  endfunction

  always_comb begin
    {inc_short, inc_held_d} = track(inc_level_i, inc_prev_q, inc_held_q, limit_q);
    {dec_short, dec_held_d} = track(dec_level_i, dec_prev_q, dec_held_q, limit_q);
    fmax  = (fmax_q == '0) ? FREQ_W'(1) : fmax_q;
    sum   = {1'b0, freq_q} + (FREQ_W + 1)'(step_q);
    f_inc = freq_q;
    if (inc_short) f_inc = (sum > {1'b0, fmax}) ? fmax : sum[FREQ_W-1:0];
    freq_d = f_inc;
    if (dec_short) freq_d = (f_inc > FREQ_W'(step_q)) ? f_inc - FREQ_W'(step_q) : FREQ_W'(1);
  end

  bal_div #(.MS_PER_PERIOD(MS_PER_PERIOD)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.take),
    .step_i    (cmd_i.div_step),
    .divisor_i (freq_q),
    .quotient_o(quo),
    .last_o    (div_last)
  );

  // Blink stage, run once per tick at emit.
  always_comb begin
    quo_half = HW'(quo >> 1);
    half_new = half_q;
    if (changed_q) half_new = (quo_half == '0) ? HW'(1) : quo_half;
    led_d   = (cnt_q == '0) ? ~led_q : led_q;
    cnt_inc = {1'b0, cnt_q} + (HW + 1)'(1);
    cnt_d   = (cnt_inc >= {1'b0, half_new}) ? '0 : cnt_inc[HW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RST;
      step_q      <= STEP_RST;
      fmax_q      <= FMAX_RST;
      freq_q      <= FREQ_RST;
      inc_prev_q  <= 1'b1;
      dec_prev_q  <= 1'b1;
      inc_held_q  <= '0;
      dec_held_q  <= '0;
      changed_q   <= 1'b0;
      led_q       <= 1'b0;
      cnt_q       <= '0;
      half_q      <= HW'(HRST);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PRESS_LIMIT: limit_q <= cfg_wdata_i[LIMIT_W-1:0];
          REG_FREQ_STEP:   step_q  <= cfg_wdata_i[STEP_W-1:0];
          REG_FREQ_MAX:    fmax_q  <= cfg_wdata_i[FREQ_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        inc_prev_q <= inc_level_i;
        dec_prev_q <= dec_level_i;
        inc_held_q <= inc_held_d;
        dec_held_q <= dec_held_d;
        freq_q     <= freq_d;
        changed_q  <= inc_short | dec_short;
      end
      if (cmd_i.emit) begin
        led_q       <= led_d;
        cnt_q       <= cnt_d;
        half_q      <= half_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_led_q  <= led_d;
      out_rate_q <= freq_q;
      out_chg_q  <= changed_q;
    end
  end

  assign sts_o.short_hit = inc_short | dec_short;
  assign sts_o.div_last  = div_last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign led_out_o      = out_led_q;
  assign blink_rate_o   = out_rate_q;
  assign rate_changed_o = out_chg_q;

endmodule

FILE: rtl/bal_ctrl.sv
// Controller FSM: takes a tick, runs the divider after a short press, emits.
// Depends on bal_pkg.
module bal_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bal_pkg::bal_sts_t sts_i,
  output bal_pkg::bal_cmd_t cmd_o
);
  import bal_pkg::*;

  bal_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.short_hit ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/button_adjusted_led_blinker_top.sv
// Button-adjusted LED blinker, top level. Each input transaction is one
// millisecond tick carrying two active-low button levels; each tick yields
// exactly one output transaction with the LED level, the blink frequency and
// a flag for an accepted short press. A tick is taken in the idle state and
// emitted in the finish state; after an accepted short press the half
// period is first recomputed by a radix-2 divider that yields one quotient
// bit a cycle. One tick is in work at a time; a finished result waits in
// the output register while the next tick is taken, and the output stage
// stalls only if that register is still full.
// Configuration writes are expected only while the block is idle.
// Depends on bal_pkg, bal_ctrl, bal_dp, bal_div and the assertion header.
module button_adjusted_led_blinker_top #(
  parameter int MS_PER_PERIOD = bal_pkg::MS_PER_PERIOD_DEF,
  parameter int TIMER_WIDTH   = bal_pkg::TIMER_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port: 0 press_limit_ticks, 1 freq_step, 2 freq_max
  input  logic                         cfg_we_i,
  input  logic [bal_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bal_pkg::CFG_W-1:0]     cfg_wdata_i,
  // tick stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [0] inc_level, [1] dec_level
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata   // [0] led_out, [9:1] blink_rate,
                                                      // [10] rate_changed
);
  import bal_pkg::*;

  bal_cmd_t          cmd;
  bal_sts_t          sts;
  logic              led_out;
  logic [FREQ_W-1:0] blink_rate;
  logic              rate_changed;

  bal_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bal_dp #(
    .MS_PER_PERIOD(MS_PER_PERIOD),
    .TIMER_WIDTH  (TIMER_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .inc_level_i   (s_axis_tdata[0]),
    .dec_level_i   (s_axis_tdata[1]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .led_out_o     (led_out),
    .blink_rate_o  (blink_rate),
    .rate_changed_o(rate_changed)
  );

  assign m_axis_tdata = {5'b0, rate_changed, blink_rate, led_out};

  // Checks
  `include "button_adjusted_led_blinker_top_assert.svh"

  // frequency never drops to zero
  `BAL_ASSERT_IMP(a_rate_nonzero, m_axis_tvalid, blink_rate != '0, "blink rate is zero")
  // one tick in work at a time: busy straight after a take
  `BAL_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "tick taken while busy")
  // a result is only loaded when the output register can take it
  `BAL_ASSERT_IMP(a_emit_free, cmd.emit, !m_axis_tvalid || m_axis_tready, "output overwritten")

endmodule
